@@ rtl/core/assert_macros.svh @@
// Assertion macros for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/core/bbc_pkg.sv @@
// Types, constants and the bracket decoder of the bracket balance checker.
`default_nettype none

package bbc_pkg;

	// Default sizes for the top-level parameters, and the error position width.
	localparam int STACK_DEPTH_DEF   = 64;
	localparam int POSITION_BITS_DEF = 16;
	localparam int ERR_POS_W         = 16;

	// Bracket kinds as held in the stack.
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_ROUND  = 2'd0;
	localparam kind_t KIND_SQUARE = 2'd1;
	localparam kind_t KIND_CURLY  = 2'd2;

	// Bracket characters.
	localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;
	localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;
	localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
	localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
	localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
	localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;

	// Verdict codes.
	localparam logic [2:0] ST_BALANCED    = 3'd0;
	localparam logic [2:0] ST_NO_BRACKETS = 3'd1;
	localparam logic [2:0] ST_SINGLE      = 3'd2;
	localparam logic [2:0] ST_MISMATCH    = 3'd3;
	localparam logic [2:0] ST_UNCLOSED    = 3'd4;
	localparam logic [2:0] ST_OVERFLOW    = 3'd5;

	// Input word: one byte of the string.
	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} char_word_t;

	// Output word: the verdict for one string.
	typedef struct packed {
		logic [2:0]           status;
		logic [ERR_POS_W-1:0] error_position;
		kind_t                bad_closer_kind;
	} verdict_word_t;

	// Shift control for the row of stack cells.
	typedef struct packed {
		logic push;
		logic pop;
	} stk_ctl_t;

	// Decoded character.
	typedef struct packed {
		logic  opener;
		logic  closer;
		kind_t kind;
	} bkt_t;

	function automatic bkt_t decode_char(logic [7:0] c);
		bkt_t b;
		b = '{opener: 1'b0, closer: 1'b0, kind: KIND_ROUND};
		unique case (c)
			CH_OPEN_ROUND:   b = '{opener: 1'b1, closer: 1'b0, kind: KIND_ROUND};
			CH_OPEN_SQUARE:  b = '{opener: 1'b1, closer: 1'b0, kind: KIND_SQUARE};
			CH_OPEN_CURLY:   b = '{opener: 1'b1, closer: 1'b0, kind: KIND_CURLY};
			CH_CLOSE_ROUND:  b = '{opener: 1'b0, closer: 1'b1, kind: KIND_ROUND};
			CH_CLOSE_SQUARE: b = '{opener: 1'b0, closer: 1'b1, kind: KIND_SQUARE};
			CH_CLOSE_CURLY:  b = '{opener: 1'b0, closer: 1'b1, kind: KIND_CURLY};
			default:         b = '{opener: 1'b0, closer: 1'b0, kind: KIND_ROUND};
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/bracket_balance_checker.sv @@
// The last word's verdict is registered in the output register, or in the skid stage.
// Throughput: one input word per cycle while char_stall is low. A closer is a
// top-of-stack compare, a push or pop one shift of the cell row. char_stall rises
// only when the output register and its skid stage both hold untaken verdicts.
// Reset clears the depth count, counters, flags and output valids; cell contents are
// only read below the depth count and need no reset.
`default_nettype none

module bracket_balance_checker #(
	parameter int STACK_DEPTH   = bbc_pkg::STACK_DEPTH_DEF,
	parameter int POSITION_BITS = bbc_pkg::POSITION_BITS_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   char_valid,
	output logic                  char_stall,
	input  bbc_pkg::char_word_t   char_word,
	output logic                  verdict_valid,
	input  wire                   verdict_stall,
	output bbc_pkg::verdict_word_t verdict_word
);
	import bbc_pkg::*;

	localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
	localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(STACK_DEPTH);
	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	// String state.
	logic [DEPTH_W-1:0]       depth_q, depth_next;
	logic [1:0]               count_q, count_next;
	logic [POSITION_BITS-1:0] pos_q, pos_next;
	logic                     mismatch_q, mismatch_next;
	logic                     overflow_q, overflow_next;
	logic [POSITION_BITS-1:0] mpos_q, mpos_next;
	kind_t                    mkind_q, mkind_next;

	// Output register and skid stage.
	logic          out_valid_q, skid_valid_q;
	verdict_word_t out_word_q, skid_word_q;
	verdict_word_t result;

	logic     accept, active, can_push, do_push, do_pop, do_close, bad, load;
	bkt_t     bkt;
	stk_ctl_t ctl;
	kind_t    cell_kind [STACK_DEPTH];

	assign accept = char_valid && !char_stall;
	assign bkt    = decode_char(char_word.character);
	assign active = !mismatch_q && !overflow_q;

	// Stack control: push into the top cell, pop pulls the row up.
	assign can_push = (depth_q != DEPTH_FULL);
	assign do_push  = accept && active && bkt.opener && can_push;
	assign do_close = accept && active && bkt.closer;
	assign do_pop   = do_close && (depth_q != '0);
	assign bad      = do_close && ((depth_q == '0) || (cell_kind[0] != bkt.kind));
	assign ctl      = '{push: do_push, pop: do_pop};

	// Row of stack cells, top of stack in cell 0.
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		kind_t prev_kind, next_kind;
		if (i == 0) begin : g_top
			assign prev_kind = bkt.kind;
		end else begin : g_mid
			assign prev_kind = cell_kind[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_bot
			assign next_kind = cell_kind[i];
		end else begin : g_up
			assign next_kind = cell_kind[i+1];
		end
		bbc_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.from_prev (prev_kind),
			.from_next (next_kind),
			.kind      (cell_kind[i])
		);
	end

	// Next string state for the byte at the input.
	always_comb begin
		pos_next      = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;
		depth_next    = depth_q;
		count_next    = count_q;
		mismatch_next = mismatch_q;
		overflow_next = overflow_q;
		mpos_next     = mpos_q;
		mkind_next    = mkind_q;
		if (do_push) begin
			depth_next = depth_q + 1'b1;
		end
		if (do_pop) begin
			depth_next = depth_q - 1'b1;
		end
		if ((do_push || do_close) && (count_q != 2'd2)) begin
			count_next = count_q + 1'b1;
		end
		if (accept && active && bkt.opener && !can_push) begin
			overflow_next = 1'b1;
		end
		if (bad) begin
			mismatch_next = 1'b1;
			mpos_next     = pos_next;
			mkind_next    = bkt.kind;
		end
	end

	// Verdict from the state after this byte, in priority order.
	always_comb begin
		priority if (overflow_next) begin
			result.status = ST_OVERFLOW;
		end else if (count_next == 2'd0) begin
			result.status = ST_NO_BRACKETS;
		end else if (count_next == 2'd1) begin
			result.status = ST_SINGLE;
		end else if (mismatch_next) begin
			result.status = ST_MISMATCH;
		end else if (depth_next != '0) begin
			result.status = ST_UNCLOSED;
		end else begin
			result.status = ST_BALANCED;
		end
		result.error_position  = mismatch_next ? ERR_POS_W'(mpos_next) : '0;
		result.bad_closer_kind = mismatch_next ? mkind_next : KIND_ROUND;
	end

	// String state registers; the last byte clears them for the next string.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q    <= '0;
			count_q    <= '0;
			pos_q      <= '0;
			mismatch_q <= 1'b0;
			overflow_q <= 1'b0;
			mpos_q     <= '0;
			mkind_q    <= KIND_ROUND;
		end else if (accept) begin
			if (char_word.last) begin
				depth_q    <= '0;
				count_q    <= '0;
				pos_q      <= '0;
				mismatch_q <= 1'b0;
				overflow_q <= 1'b0;
				mpos_q     <= '0;
				mkind_q    <= KIND_ROUND;
			end else begin
				depth_q    <= depth_next;
				count_q    <= count_next;
				pos_q      <= pos_next;
				mismatch_q <= mismatch_next;
				overflow_q <= overflow_next;
				mpos_q     <= mpos_next;
				mkind_q    <= mkind_next;
			end
		end
	end

	// Output register with a skid stage behind it.
	assign load       = accept && char_word.last;
	assign char_stall = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || !verdict_stall) begin
			out_valid_q  <= skid_valid_q || load;
			skid_valid_q <= 1'b0;
		end else if (load) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !verdict_stall) begin
			out_word_q <= skid_valid_q ? skid_word_q : result;
		end else if (load) begin
			skid_word_q <= result;
		end
	end

	assign verdict_valid = out_valid_q;
	assign verdict_word  = out_word_q;

endmodule

`default_nettype wire

@@ rtl/core/bbc_cell.sv @@
// One cell of the shifting bracket stack: holds one bracket kind.
`default_nettype none

module bbc_cell (
	input  wire              clk,
	input  bbc_pkg::stk_ctl_t ctl,
	input  bbc_pkg::kind_t   from_prev,
	input  bbc_pkg::kind_t   from_next,
	output bbc_pkg::kind_t   kind
);
	import bbc_pkg::*;

	kind_t kind_q;

	// A push moves every entry one cell deeper; a pop moves every entry up.
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			kind_q <= from_prev;
		end else if (ctl.pop) begin
			kind_q <= from_next;
		end
	end

	assign kind = kind_q;

endmodule

`default_nettype wire

@@ rtl/core/bbc_checker.sv @@
// Port-level checks of the bracket balance checker and their bind.
`default_nettype none

`include "assert_macros.svh"

module bbc_checker (
	input wire                    clk,
	input wire                    arst_n,
	input wire                    char_stall,
	input wire                    verdict_valid,
	input wire                    verdict_stall,
	input bbc_pkg::verdict_word_t verdict_word
);
	import bbc_pkg::*;

	logic no_mis_status, no_mis_fields, mis_status, mis_fields;

	// Verdicts that rule out a recorded mismatch, and the fields they must carry.
	assign no_mis_status = verdict_word.status == ST_BALANCED ||
		verdict_word.status == ST_NO_BRACKETS || verdict_word.status == ST_UNCLOSED ||
		verdict_word.status == ST_OVERFLOW;
	assign no_mis_fields = verdict_word.error_position == '0 &&
		verdict_word.bad_closer_kind == KIND_ROUND;

	// A mismatch verdict names a nonzero position and a real closer kind.
	assign mis_status = verdict_word.status == ST_MISMATCH;
	assign mis_fields = verdict_word.error_position != '0 &&
		verdict_word.bad_closer_kind <= KIND_CURLY;

	// A verdict held back keeps its value.
	`ASSERT_NEXT(a_hold, clk, arst_n, verdict_valid && verdict_stall, verdict_valid && $stable(verdict_word))

	// Input is held back only while a verdict waits at the output.
	`ASSERT_SAME(a_stall_out, clk, arst_n, char_stall, verdict_valid)

	// Verdicts that exclude a mismatch carry no mismatch position or kind.
	`ASSERT_SAME(a_no_pos, clk, arst_n, verdict_valid && no_mis_status, no_mis_fields)

	// A mismatch verdict always names a position.
	`ASSERT_SAME(a_mis_pos, clk, arst_n, verdict_valid && mis_status, mis_fields)

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.char_stall    (char_stall),
	.verdict_valid (verdict_valid),
	.verdict_stall (verdict_stall),
	.verdict_word  (verdict_word)
);

`default_nettype wire
